[sv/frx_pkg.sv]
`default_nettype none

package frx_pkg;

    // header markers and register reset value
    localparam logic [7:0]  MARK_FIRST        = 8'h55;
    localparam logic [7:0]  MARK_SECOND       = 8'hAA;
    localparam logic [15:0] FLUSH_TICKS_RESET = 16'd100;

    // header is six bytes; index of the last one
    localparam int          HDR_BYTES = 6;
    localparam logic [2:0]  HDR_LAST  = 3'd5;

    // input command codes
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_ARM  = 2'd2;

    // result kind codes
    localparam logic [2:0] KIND_ACK     = 3'd0;
    localparam logic [2:0] KIND_BYTE    = 3'd1;
    localparam logic [2:0] KIND_END     = 3'd2;
    localparam logic [2:0] KIND_BAD     = 3'd3;
    localparam logic [2:0] KIND_FLUSHED = 3'd4;

    // receiver mode, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_HEADER  = 5'b00010,
        MODE_PAYLOAD = 5'b00100,
        MODE_TAIL    = 5'b01000,
        MODE_FLUSH   = 5'b10000
    } mode_t;

    // one input word
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } item_t;

    // one result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] frame_type;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic        last;
        logic        ack_seen;
    } res_t;

endpackage

`default_nettype wire

[sv/module_frame_receiver_core.sv]
// Path: an input word passes the input register, then the result register,
// before its result word is on the master side. Throughput: one input word
// per cycle unless the result side stalls; the state update is a single pass.
// Reset: synchronous, active low; receiver goes idle, ack flag clears and
// flush_ticks returns to 100. Header bytes are not cleared.
`default_nettype none

module module_frame_receiver_core
    import frx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // flush_ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,       // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,       // [15:0] frame_type, [31:16] frame_length,
                                            // [39:32] payload_byte, [40] ack_seen
    output logic [2:0]       m_tuser,       // [2:0] kind
    output logic             m_tlast
);

    logic  item_valid;
    logic  item_take;
    item_t item;
    logic  out_ready;
    logic  res_valid;
    res_t  res;

    frx_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    frx_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .out_ready   (out_ready),
        .item_take   (item_take),
        .res_valid   (res_valid),
        .res         (res)
    );

    frx_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

[sv/frx_in_stage.sv]
`default_nettype none

module frx_in_stage
    import frx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0] s_tuser,   // [1:0] command
    input  wire logic       item_take,
    output logic            item_valid,
    output item_t           item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // register is free when empty or being consumed this cycle
    assign s_tready   = !valid_reg || item_take;
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command <= s_tuser;
            item_reg.rx_byte <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[sv/frx_fsm.sv]
`default_nettype none

module frx_fsm
    import frx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        item_valid,
    input  wire item_t       item,
    input  wire logic        out_ready,
    output logic             item_take,
    output logic             res_valid,
    output res_t             res
);

    mode_t       mode_reg, mode_next;
    logic [2:0]  hdr_count_reg, hdr_count_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] flush_count_reg, flush_count_next;
    logic        ack_flag_reg, ack_flag_next;
    logic [15:0] flush_ticks_reg;
    logic [7:0]  hdr_reg [HDR_BYTES];
    logic        hdr_wr;
    logic        fire;
    logic        emit;
    logic [2:0]  kind;
    logic [7:0]  pay_byte;
    logic        is_last;
    logic [15:0] flush_inc;
    logic        hdr_done;
    logic [15:0] cur_type;
    logic [15:0] cur_length;

    // one word processed per cycle when the result side can take it
    assign fire      = item_valid && out_ready;
    assign item_take = fire;

    assign flush_inc = flush_count_reg + 16'd1;
    assign hdr_done  = (hdr_count_reg == HDR_LAST);
    assign is_last   = (bytes_left_reg <= 16'd1);

    // header fields; on the final header byte the length high byte is the input
    always_comb begin
        cur_type   = {hdr_reg[3], hdr_reg[2]};
        cur_length = {hdr_reg[5], hdr_reg[4]};
        if (mode_reg == MODE_HEADER && hdr_done) begin
            cur_length = {item.rx_byte, hdr_reg[4]};
        end
    end

    // next state and result decision
    always_comb begin
        mode_next        = mode_reg;
        hdr_count_next   = hdr_count_reg;
        bytes_left_next  = bytes_left_reg;
        flush_count_next = flush_count_reg;
        ack_flag_next    = ack_flag_reg;
        hdr_wr           = 1'b0;
        emit             = 1'b0;
        kind             = KIND_ACK;
        pay_byte         = 8'd0;
        case (item.command)
            CMD_ARM: begin
                ack_flag_next  = 1'b0;
                mode_next      = MODE_HEADER;
                hdr_count_next = 3'd0;
            end
            CMD_TICK: begin
                if (mode_reg == MODE_FLUSH) begin
                    flush_count_next = flush_inc;
                    if (flush_inc >= flush_ticks_reg) begin
                        mode_next = MODE_IDLE;
                        emit      = 1'b1;
                        kind      = KIND_FLUSHED;
                    end
                end
            end
            CMD_BYTE: begin
                case (mode_reg)
                    MODE_HEADER: begin
                        hdr_wr = 1'b1;
                        if (!hdr_done) begin
                            hdr_count_next = hdr_count_reg + 3'd1;
                        end else begin
                            hdr_count_next = 3'd0;
                            if (hdr_reg[0] != MARK_FIRST || hdr_reg[1] != MARK_SECOND) begin
                                mode_next        = MODE_FLUSH;
                                flush_count_next = 16'd0;
                                emit             = 1'b1;
                                kind             = KIND_BAD;
                            end else if (cur_type == 16'd0) begin
                                ack_flag_next = 1'b1;
                                mode_next     = MODE_IDLE;
                                emit          = 1'b1;
                                kind          = KIND_ACK;
                            end else begin
                                bytes_left_next = cur_length;
                                mode_next = (cur_length == 16'd0) ? MODE_TAIL : MODE_PAYLOAD;
                            end
                        end
                    end
                    MODE_PAYLOAD: begin
                        emit     = 1'b1;
                        kind     = KIND_BYTE;
                        pay_byte = item.rx_byte;
                        if (is_last) begin
                            bytes_left_next = 16'd0;
                            mode_next       = MODE_TAIL;
                        end else begin
                            bytes_left_next = bytes_left_reg - 16'd1;
                        end
                    end
                    MODE_TAIL: begin
                        mode_next = MODE_IDLE;
                        emit      = 1'b1;
                        kind      = KIND_END;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            hdr_count_reg   <= 3'd0;
            bytes_left_reg  <= 16'd0;
            flush_count_reg <= 16'd0;
            ack_flag_reg    <= 1'b0;
        end else if (fire) begin
            mode_reg        <= mode_next;
            hdr_count_reg   <= hdr_count_next;
            bytes_left_reg  <= bytes_left_next;
            flush_count_reg <= flush_count_next;
            ack_flag_reg    <= ack_flag_next;
        end
    end

    // flush length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_ticks_reg <= FLUSH_TICKS_RESET;
        end else if (cfg_wr_en) begin
            flush_ticks_reg <= cfg_wr_data;
        end
    end

    // header byte store, undefined until written
    always_ff @(posedge aclk) begin
        if (fire && hdr_wr) begin
            hdr_reg[hdr_count_reg] <= item.rx_byte;
        end
    end

    assign res_valid        = fire && emit;
    assign res.kind         = kind;
    assign res.frame_type   = cur_type;
    assign res.frame_length = cur_length;
    assign res.payload_byte = pay_byte;
    assign res.last         = (kind == KIND_BYTE) && is_last;
    assign res.ack_seen     = ack_flag_next;

endmodule

`default_nettype wire

[sv/frx_out_stage.sv]
`default_nettype none

module frx_out_stage
    import frx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        res_valid,
    input  wire res_t        res,
    output logic             out_ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [15:0] frame_type, [31:16] frame_length,
                                        // [39:32] payload_byte, [40] ack_seen
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast
);

    logic valid_reg;
    res_t res_reg;

    // result register can load when empty or drained this cycle
    assign out_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, res_reg.ack_seen, res_reg.payload_byte,
                       res_reg.frame_length, res_reg.frame_type};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

`default_nettype wire

[verif/module_frame_receiver_core_test.sv]
`timescale 1ns / 100ps

module module_frame_receiver_core_test;
    import frx_pkg::*;

    // spare command code, no meaning to the receiver
    localparam logic [1:0] CMD_SPARE     = 2'd3;
    // the block answers through its input and result registers; allow some slack
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 600000;

    // Scoreboard: tracks the receiver state and the reply words still owed
    class frame_scoreboard;
        res_t        owed_q[$];
        int          mismatches;
        mode_t       mode;
        int unsigned hdr_count;
        logic [7:0]  hdr_bytes[HDR_BYTES];
        logic [15:0] bytes_left;
        logic [15:0] flush_count;
        logic [15:0] flush_ticks;
        logic        ack_flag;

        function new();
            mismatches  = 0;
            mode        = MODE_IDLE;
            hdr_count   = 0;
            bytes_left  = '0;
            flush_count = '0;
            flush_ticks = FLUSH_TICKS_RESET;
            ack_flag    = 1'b0;
            foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        endfunction

        function void set_flush_ticks(logic [15:0] ticks);
            flush_ticks = ticks;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // reply word carrying the latest complete header
        function void owe_word(logic [2:0] kind, logic [7:0] data, logic is_last);
            res_t r;
            r.kind         = kind;
            r.frame_type   = {hdr_bytes[3], hdr_bytes[2]};
            r.frame_length = {hdr_bytes[5], hdr_bytes[4]};
            r.payload_byte = data;
            r.last         = is_last;
            r.ack_seen     = ack_flag;
            owed_q.push_back(r);
        endfunction

        // advance the receiver by one accepted input word
        function void note_word(logic [1:0] command, logic [7:0] rx_byte);
            logic last_byte;
            case (command)
                CMD_ARM: begin
                    ack_flag  = 1'b0;
                    mode      = MODE_HEADER;
                    hdr_count = 0;
                end
                CMD_TICK: begin
                    if (mode == MODE_FLUSH) begin
                        flush_count = flush_count + 16'd1;
                        if (flush_count >= flush_ticks) begin
                            mode = MODE_IDLE;
                            owe_word(KIND_FLUSHED, 8'h00, 1'b0);
                        end
                    end
                end
                CMD_BYTE: begin
                    case (mode)
                        MODE_HEADER: begin
                            hdr_bytes[hdr_count] = rx_byte;
                            hdr_count++;
                            if (hdr_count == HDR_BYTES) begin
                                hdr_count = 0;
                                if (hdr_bytes[0] != MARK_FIRST ||
                                    hdr_bytes[1] != MARK_SECOND) begin
                                    mode        = MODE_FLUSH;
                                    flush_count = '0;
                                    owe_word(KIND_BAD, 8'h00, 1'b0);
                                end else if ({hdr_bytes[3], hdr_bytes[2]} == 16'h0000) begin
                                    ack_flag = 1'b1;
                                    mode     = MODE_IDLE;
                                    owe_word(KIND_ACK, 8'h00, 1'b0);
                                end else begin
                                    bytes_left = {hdr_bytes[5], hdr_bytes[4]};
                                    mode = (bytes_left == 16'h0000) ? MODE_TAIL : MODE_PAYLOAD;
                                end
                            end
                        end
                        MODE_PAYLOAD: begin
                            last_byte  = (bytes_left <= 16'd1);
                            bytes_left = bytes_left - 16'd1;
                            if (last_byte) begin
                                bytes_left = '0;
                                mode       = MODE_TAIL;
                            end
                            owe_word(KIND_BYTE, rx_byte, last_byte);
                        end
                        MODE_TAIL: begin
                            mode = MODE_IDLE;
                            owe_word(KIND_END, 8'h00, 1'b0);
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [15:0] seen, logic [15:0] want);
            if (seen !== want)
                report($sformatf("%s: got %h, want %h", name, seen, want));
        endtask

        // compare an accepted reply word with the oldest one owed
        task check_word(logic [2:0] kind, logic [15:0] ftype, logic [15:0] flen,
                        logic [7:0] data, logic is_last, logic ack);
            res_t want;
            if (owed_q.size() == 0) begin
                report($sformatf("reply word kind %0d with nothing owed", kind));
                return;
            end
            want = owed_q.pop_front();
            check_field("kind", 16'(kind), 16'(want.kind));
            check_field("frame_type", ftype, want.frame_type);
            check_field("frame_length", flen, want.frame_length);
            check_field("payload_byte", 16'(data), 16'(want.payload_byte));
            check_field("last", 16'(is_last), 16'(want.last));
            check_field("ack_seen", 16'(ack), 16'(want.ack_seen));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] rx_byte
    logic [1:0]  s_tuser;      // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;      // [15:0] frame_type, [31:16] frame_length,
                               // [39:32] payload_byte, [40] ack_seen
    logic [2:0]  m_tuser;      // [2:0] kind
    logic        m_tlast;

    frame_scoreboard board;
    int unsigned     src_idle_pct;
    int unsigned     sink_idle_pct;
    int unsigned     sink_hold = 0;
    int unsigned     words_sent;
    int unsigned     cycle_count = 0;
    logic [15:0]     flush_setting;

    module_frame_receiver_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("module_frame_receiver_core regression: fail");
            $finish;
        end
    end

    // sink stalls in bursts of random length
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (sink_idle_pct != 0 && $urandom_range(99, 0) < sink_idle_pct) begin
            sink_hold <= $urandom_range(5, 0);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // reply word monitor
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            board.check_word(m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[39:32],
                             m_tlast, m_tdata[40]);
    end

    // one input word, with an optional gap before it
    task automatic send_word(logic [1:0] command, logic [7:0] rx_byte);
        if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= command;
        s_tdata  <= rx_byte;
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.note_word(command, rx_byte);
        words_sent++;
    endtask

    // first count bytes of a header
    task automatic send_header(logic [7:0] m0, logic [7:0] m1, logic [15:0] ftype,
                               logic [15:0] flen, int unsigned count);
        logic [7:0] hb[HDR_BYTES];
        hb = '{m0, m1, ftype[7:0], ftype[15:8], flen[7:0], flen[15:8]};
        for (int i = 0; i < count; i++)
            send_word(CMD_BYTE, hb[i]);
    endtask

    // hold off until every owed reply has come, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_flush_ticks(logic [15:0] ticks);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_flush_ticks(ticks);
        flush_setting = ticks;
    endtask

    task automatic pick_idling();
        src_idle_pct  = $urandom_range(2, 0) * 12;
        sink_idle_pct = $urandom_range(2, 0) * 12;
    endtask

    // mostly well-formed frames with random content, some noise and breakage
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned n;
        int unsigned ticks;
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [15:0] ftype;
        logic [15:0] flen;
        logic        bad;
        pick = $urandom_range(99, 0);
        if (pick < 8) begin
            repeat ($urandom_range(4, 1))
                send_word(2'($urandom_range(3, 0)), 8'($urandom));
            return;
        end
        if (pick >= 13)
            send_word(CMD_ARM, 8'($urandom));
        m0   = MARK_FIRST;
        m1   = MARK_SECOND;
        pick = $urandom_range(99, 0);
        if (pick < 6)
            m0 = 8'($urandom);
        else if (pick < 12)
            m1 = 8'($urandom);
        bad  = (m0 != MARK_FIRST) || (m1 != MARK_SECOND);
        pick = $urandom_range(99, 0);
        if (pick < 20)
            ftype = 16'h0000;
        else if (pick < 30)
            ftype = 16'hFFFF;
        else
            ftype = 16'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 15)
            flen = 16'h0000;
        else if (pick < 20)
            flen = 16'hFFFF;
        else if (pick < 70)
            flen = 16'($urandom_range(8, 1));
        else
            flen = 16'($urandom_range(40, 9));

        // truncated header, restarted by the next arm
        if ($urandom_range(99, 0) < 8) begin
            send_header(m0, m1, ftype, flen, $urandom_range(HDR_BYTES - 1, 1));
            return;
        end
        send_header(m0, m1, ftype, flen, HDR_BYTES);

        if (bad) begin
            // stray bytes are discarded, then tick the flush out (or cut it short)
            repeat ($urandom_range(3, 0)) send_word(CMD_BYTE, 8'($urandom));
            ticks = (flush_setting == 16'h0000) ? 1 : flush_setting;
            if ($urandom_range(99, 0) < 80)
                ticks += $urandom_range(2, 0);
            else
                ticks = $urandom_range(ticks - 1, 0);
            repeat (ticks) send_word(CMD_TICK, 8'($urandom));
        end else if (ftype == 16'h0000) begin
            repeat ($urandom_range(3, 0)) send_word(CMD_BYTE, 8'($urandom));
        end else begin
            // huge frames get cut short by the next arm
            n = (flen == 16'hFFFF) ? $urandom_range(6, 0) : flen;
            if ($urandom_range(99, 0) < 8)
                n = $urandom_range(n, 0);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(99, 0) < 5)
                    send_word($urandom_range(1, 0) ? CMD_TICK : CMD_SPARE, 8'($urandom));
                send_word(CMD_BYTE, 8'($urandom));
            end
            if (n == flen)
                send_word(CMD_BYTE, 8'($urandom));
        end
    endtask

    task automatic send_random_words(int unsigned count);
        int unsigned start;
        start = words_sent;
        while (words_sent - start < count) begin
            send_random_frame();
            if ($urandom_range(99, 0) < 3)
                drain_results();
        end
    endtask

    // Main sequence
    initial begin
        board         = new();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        words_sent    = 0;
        flush_setting = FLUSH_TICKS_RESET;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_BYTE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ignored words, ack with a length, widest type, empty payload
        send_word(CMD_SPARE, 8'hFF);
        send_word(CMD_BYTE, 8'h55);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_ARM, 8'h00);
        send_header(MARK_FIRST, MARK_SECOND, 16'h0000, 16'h0002, HDR_BYTES);
        send_word(CMD_BYTE, 8'hA5);
        send_word(CMD_ARM, 8'hFF);
        send_header(MARK_FIRST, MARK_SECOND, 16'hFFFF, 16'h0001, HDR_BYTES);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_ARM, 8'h00);
        send_header(MARK_FIRST, MARK_SECOND, 16'h0001, 16'h0000, HDR_BYTES);
        send_word(CMD_BYTE, 8'h5A);
        pick_idling();
        send_random_words(60);

        // zero ticks: flush ends on the first tick; arm ends a flush silently
        write_flush_ticks(16'h0000);
        send_word(CMD_ARM, 8'h00);
        send_header(8'h00, MARK_SECOND, 16'h0042, 16'h0003, HDR_BYTES);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_ARM, 8'h00);
        send_header(MARK_FIRST, MARK_FIRST, 16'h0000, 16'hFFFF, HDR_BYTES);
        send_word(CMD_ARM, 8'h00);
        pick_idling();
        send_random_words(70);

        write_flush_ticks(16'h0001);
        pick_idling();
        send_random_words(70);

        // widest flush: ticks well short of it end nothing, an arm ends it quietly
        write_flush_ticks(16'hFFFF);
        src_idle_pct = 0;
        send_word(CMD_ARM, 8'h00);
        send_header(MARK_FIRST, 8'hAB, 16'h1234, 16'h0003, HDR_BYTES);
        repeat (40) send_word(CMD_TICK, 8'($urandom));
        send_word(CMD_BYTE, 8'($urandom));
        send_word(CMD_TICK, 8'($urandom));
        send_word(CMD_ARM, 8'h00);

        for (int p = 0; p < 3; p++) begin
            write_flush_ticks(16'($urandom_range(12, 2)));
            pick_idling();
            send_random_words(70);
        end

        // last stretch without idling
        write_flush_ticks(16'd5);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_words(90);

        drain_results();
        if (board.mismatches == 0)
            $display("module_frame_receiver_core regression: pass");
        else
            $display("module_frame_receiver_core regression: fail");
        $finish;
    end

endmodule
